// ===== sv/sdhs_pkg.sv =====
// ---------------------------------------------------------------------------
// SCAN disk head scheduler package
// Field widths and the command and status bundles between the controller
// and the datapath.
// ---------------------------------------------------------------------------
package sdhs_pkg;

  localparam int TRACK_W = 16;
  localparam int SEEK_W  = 17;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store one request
    logic start;       // begin a batch: reload head, clear seek and served marks
    logic pass_start;  // begin one search pass over the store
    logic scan;        // search pass in progress
    logic latch;       // search finished: register the result
    logic finish;      // final result transferred: empty the store
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_last;
  } dp_stat_t;

endpackage

// ===== sv/sdhs_datapath.sv =====
// ---------------------------------------------------------------------------
// SCAN scheduler datapath
// Request store, one-entry-per-cycle search for the next track in the sweep,
// seek accumulation and the result register.
// ---------------------------------------------------------------------------
module sdhs_datapath import sdhs_pkg::*; #(
  parameter int MAX_REQUESTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               cfg_we,
  input  logic [TRACK_W-1:0] cfg_wdata,
  input  logic [TRACK_W-1:0] request_track,
  output logic [TRACK_W-1:0] served_track,
  output logic [SEEK_W-1:0]  seek_total,
  output logic               last_served
);

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [TRACK_W-1:0]      mem [MAX_REQUESTS];
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        scan_cnt;
  logic                    rd_valid;
  logic [IDX_W-1:0]        rd_idx;
  logic [TRACK_W-1:0]      rd_data;
  logic [MAX_REQUESTS-1:0] served;
  logic                    phase_hi;
  logic [TRACK_W-1:0]      best_val;
  logic [IDX_W-1:0]        best_idx;
  logic                    best_found;
  logic [CNT_W-1:0]        hi_cnt;
  logic [TRACK_W-1:0]      start_head;
  logic [TRACK_W-1:0]      head;
  logic [SEEK_W-1:0]       seek;

  logic                    issue;
  logic                    is_lo;
  logic                    is_hi;
  logic                    live;
  logic                    take;
  logic [TRACK_W-1:0]      out_track;
  logic [TRACK_W-1:0]      seek_step;
  logic [SEEK_W-1:0]       seek_next;

  assign issue = cmd.scan && (scan_cnt < count);

  // Store: one write port for loading, one registered read port for searching.
  always_ff @(posedge clk) begin
    if (cmd.load && (count < CNT_MAX)) begin
      mem[count[IDX_W-1:0]] <= request_track;
    end
    if (issue) begin
      rd_data <= mem[scan_cnt[IDX_W-1:0]];
    end
    rd_idx <= scan_cnt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      scan_cnt <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count <= '0;
      end else if (cmd.load && (count < CNT_MAX)) begin
        count <= count + CNT_ONE;
      end
      if (cmd.pass_start) begin
        scan_cnt <= '0;
      end else if (issue) begin
        scan_cnt <= scan_cnt + CNT_ONE;
      end
      rd_valid <= issue;
    end
  end

  // Entries already served or equal to the start head never qualify.
  assign is_lo = rd_data < start_head;
  assign is_hi = rd_data > start_head;
  assign live  = rd_valid && !served[rd_idx];
  assign take  = live && (phase_hi ? (is_hi && (!best_found || (rd_data < best_val)))
                                   : (is_lo && (!best_found || (rd_data > best_val))));

  always_ff @(posedge clk) begin
    if (cmd.pass_start) begin
      best_found <= 1'b0;
      hi_cnt     <= '0;
    end else begin
      if (take) begin
        best_val   <= rd_data;
        best_idx   <= rd_idx;
        best_found <= 1'b1;
      end
      if (live && is_hi) begin
        hi_cnt <= hi_cnt + CNT_ONE;
      end
    end
  end

  // When the downward search finds nothing, the sweep ends at track 0.
  assign out_track = best_found ? best_val : '0;
  assign seek_step = (out_track > head) ? (out_track - head) : (head - out_track);
  assign seek_next = seek + {1'b0, seek_step};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_head <= '0;
      head       <= '0;
      seek       <= '0;
      phase_hi   <= 1'b0;
      served     <= '0;
    end else begin
      if (cfg_we) begin
        start_head <= cfg_wdata;
        head       <= cfg_wdata;
      end else if (cmd.start) begin
        head     <= start_head;
        seek     <= '0;
        phase_hi <= 1'b0;
        served   <= '0;
      end else if (cmd.latch) begin
        head <= out_track;
        seek <= seek_next;
        if (best_found) begin
          served[best_idx] <= 1'b1;
        end
        if (!phase_hi && !best_found) begin
          phase_hi <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      served_track <= out_track;
      seek_total   <= seek_next;
      last_served  <= phase_hi ? (hi_cnt == CNT_ONE) : (!best_found && (hi_cnt == '0));
    end
  end

  assign stat.scan_done = (scan_cnt == count) && !rd_valid;
  assign stat.out_last  = last_served;

endmodule

// ===== sv/sdhs_ctrl.sv =====
// ---------------------------------------------------------------------------
// SCAN scheduler controller
// Sequences loading, one search pass per result, and result transfer.
// ---------------------------------------------------------------------------
module sdhs_ctrl import sdhs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     last_request,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_xfer;
  logic       out_xfer;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  assign cmd.load       = in_xfer;
  assign cmd.start      = in_xfer && last_request;
  assign cmd.pass_start = cmd.start || (out_xfer && !stat.out_last);
  assign cmd.scan       = (state == S_SCAN);
  assign cmd.latch      = (state == S_SCAN) && stat.scan_done;
  assign cmd.finish     = out_xfer && stat.out_last;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_xfer) begin
          state_next = stat.out_last ? S_IDLE : S_SCAN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/scan_disk_head_scheduler.sv =====
// ---------------------------------------------------------------------------
// SCAN disk head scheduler
// Collects a batch of track requests, then emits them in elevator order:
// downward from the start head, track 0, then upward, with running seek total.
// ---------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  config   cfg_we                 cfg_wdata (start_head)
//  in       in_valid / in_ready    request_track, last_request
//  out      out_valid / out_ready  served_track, seek_total, last_served
//
// Requests load at one per cycle. After the marked request, each result needs
// a search pass (one store read per cycle over the N stored requests) and then
// its transfer; a batch gives up to N + 1 results. No request is taken while a
// batch is being emitted. Reset empties the store and sets the start head to 0.
// A stalled result holds its register.
// ---------------------------------------------------------------------------
module scan_disk_head_scheduler import sdhs_pkg::*; #(
  parameter int MAX_REQUESTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [TRACK_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TRACK_W-1:0] request_track,
  input  logic               last_request,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TRACK_W-1:0] served_track,
  output logic [SEEK_W-1:0]  seek_total,
  output logic               last_served
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sdhs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_request (last_request),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  sdhs_datapath #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .request_track (request_track),
    .served_track  (served_track),
    .seek_total    (seek_total),
    .last_served   (last_served)
  );

endmodule

// ===== sv/sdhs_checker.sv =====
// ---------------------------------------------------------------------------
// SCAN scheduler port checker
// Checks sequencing of the request and result channels seen at the ports.
// ---------------------------------------------------------------------------
module sdhs_checker import sdhs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               last_request,
  input logic               out_valid,
  input logic               out_ready,
  input logic [TRACK_W-1:0] served_track,
  input logic [SEEK_W-1:0]  seek_total,
  input logic               last_served
);

  // After reset the block waits for requests and shows no result.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // Requests are never taken while a result is on offer.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid both high");

  // The marked request closes the batch; loading stops.
  a_batch_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_request) |=> !in_ready)
    else $error("request taken after the final request of a batch");

  // The final result returns the block to loading.
  a_batch_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_served) |=> (in_ready && !out_valid))
    else $error("block not idle after the final result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(served_track) && $stable(seek_total) && $stable(last_served)))
    else $error("stalled result changed");

endmodule

bind scan_disk_head_scheduler sdhs_checker u_sdhs_checker (.*);

// ===== sim/scan_order_checker.sv =====
// ---------------------------------------------------------------------------
// SCAN scheduler order checker
// Watches the config, request and result channels of the scheduler. Keeps its
// own copy of the start head and the pending batch. When the marked request
// is taken, it works out the elevator service order with running seek totals.
// Each result transfer is compared field by field with the oldest expectation.
// ---------------------------------------------------------------------------
module scan_order_checker import sdhs_pkg::*; #(
  parameter int MAX_REQUESTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [TRACK_W-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [TRACK_W-1:0] request_track,
  input  logic               last_request,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [TRACK_W-1:0] served_track,
  input  logic [SEEK_W-1:0]  seek_total,
  input  logic               last_served,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Sort keys at or above this value belong to the upward sweep.
  localparam int unsigned ABOVE_HEAD = 1 << TRACK_W;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic [SEEK_W-1:0]  seek;
    logic               last;
  } visit_t;

  visit_t             due_visits[$];
  logic [TRACK_W-1:0] batch_tracks [MAX_REQUESTS];
  int                 batch_n = 0;
  logic [TRACK_W-1:0] sweep_origin = '0;
  int                 results_seen = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string note);
    $display("%0t ns  result %0d: %s", $time, results_seen, note);
    mismatches++;
  endtask

  // Builds the service order of the stored batch and queues it.
  task automatic plan_sweep();
    int unsigned        keys [MAX_REQUESTS + 1];
    int unsigned        key;
    int                 n;
    int                 i;
    int                 j;
    logic [TRACK_W-1:0] here;
    logic [TRACK_W-1:0] trk;
    logic [TRACK_W-1:0] step;
    logic [SEEK_W-1:0]  travel;
    visit_t             v;
    // Tracks below the head are keyed by their distance from it, so that an
    // ascending sort yields the downward sweep first. Track 0 as the sweep
    // end is always present. Tracks above the head follow in track order.
    keys[0] = 32'(sweep_origin);
    n = 1;
    for (i = 0; i < batch_n; i++) begin
      if (batch_tracks[i] < sweep_origin) begin
        keys[n] = 32'(sweep_origin) - 32'(batch_tracks[i]);
        n++;
      end else if (batch_tracks[i] > sweep_origin) begin
        keys[n] = ABOVE_HEAD + 32'(batch_tracks[i]);
        n++;
      end
    end
    for (i = 1; i < n; i++) begin
      key = keys[i];
      j = i;
      while (j > 0 && keys[j - 1] > key) begin
        keys[j] = keys[j - 1];
        j--;
      end
      keys[j] = key;
    end
    here = sweep_origin;
    travel = '0;
    for (i = 0; i < n; i++) begin
      if (keys[i] >= ABOVE_HEAD) trk = TRACK_W'(keys[i] - ABOVE_HEAD);
      else trk = TRACK_W'(32'(sweep_origin) - keys[i]);
      step = (trk > here) ? trk - here : here - trk;
      travel = travel + SEEK_W'(step);
      here = trk;
      v.track = trk;
      v.seek = travel;
      v.last = (i == n - 1);
      due_visits.insert(due_visits.size(), v);
    end
  endtask

  always @(posedge clk) begin : watch
    visit_t want;
    if (rst) begin
      due_visits.delete();
      batch_n = 0;
      sweep_origin = '0;
    end else begin
      if (cfg_we) sweep_origin = cfg_wdata;
      if (in_valid && in_ready) begin
        // A full store drops the request, but its mark still counts.
        if (batch_n < MAX_REQUESTS) begin
          batch_tracks[batch_n] = request_track;
          batch_n++;
        end
        if (last_request) begin
          plan_sweep();
          batch_n = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (due_visits.size() == 0) begin
          report_mismatch($sformatf("transfer of track %0d with no result pending",
                                    served_track));
        end else begin
          want = due_visits.pop_front();
          if (served_track !== want.track)
            report_mismatch($sformatf("served_track %0d, expected %0d",
                                      served_track, want.track));
          if (seek_total !== want.seek)
            report_mismatch($sformatf("seek_total %0d, expected %0d",
                                      seek_total, want.seek));
          if (last_served !== want.last)
            report_mismatch($sformatf("last_served %0b, expected %0b",
                                      last_served, want.last));
        end
        results_seen++;
      end
    end
    outstanding = due_visits.size();
  end

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// SCAN disk head scheduler testbench
// Loads request batches under a range of start heads: a directed set of edge
// cases, then random batches of 1 to 20 requests, overflow included. Both
// channels idle in random bursts; the result side also holds off for long
// stretches. A checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sdhs_pkg::*;

  localparam int MAX_REQ     = 16;
  localparam int ITEM_GOAL   = 375;
  localparam int QUIET_ITEMS = 60;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 6;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [TRACK_W-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [TRACK_W-1:0] request_track;
  logic               last_request;
  logic               out_valid;
  logic               out_ready;
  logic [TRACK_W-1:0] served_track;
  logic [SEEK_W-1:0]  seek_total;
  logic               last_served;
  int                 mismatches;
  int                 outstanding;

  bit                 quiet = 1'b0;
  int                 items_sent = 0;
  int                 batches = 0;
  int                 head_writes = 0;
  int                 overflows = 0;
  int                 tracks_served = 0;
  logic [TRACK_W-1:0] cur_head = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scan_disk_head_scheduler #(.MAX_REQUESTS(MAX_REQ)) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .request_track(request_track), .last_request(last_request),
    .out_valid(out_valid), .out_ready(out_ready),
    .served_track(served_track), .seek_total(seek_total),
    .last_served(last_served)
  );

  scan_order_checker #(.MAX_REQUESTS(MAX_REQ)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .request_track(request_track), .last_request(last_request),
    .out_valid(out_valid), .out_ready(out_ready),
    .served_track(served_track), .seek_total(seek_total),
    .last_served(last_served),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracks_served <= tracks_served + 1;
  end

  // Offers one request and returns at the edge where it transfers.
  task automatic send(input logic [TRACK_W-1:0] trk, input logic mark);
    bit took;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    request_track <= trk;
    last_request <= mark;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    items_sent++;
    if (mark) batches++;
  endtask

  task automatic drain_wait();
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_head(input logic [TRACK_W-1:0] head);
    in_valid <= 1'b0;
    drain_wait();
    cfg_we <= 1'b1;
    cfg_wdata <= head;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_head = head;
    head_writes++;
  endtask

  // Result side: random bursts of ready and stall, plus two long hold-offs
  // that back the block up into its request channel.
  initial begin : sink
    int bursts;
    bursts = 0;
    forever begin
      bursts++;
      if (!quiet && (bursts == 40 || bursts == 160)) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int                 size;
    int                 k;
    logic [TRACK_W-1:0] trk;
    logic [TRACK_W-1:0] prev;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    request_track <= '0;
    last_request <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Mixed batch: request equal to the head, request at track 0, both ends.
    set_head(16'd100);
    send(16'd50, 1'b0);
    send(16'd150, 1'b0);
    send(16'd100, 1'b0);
    send(16'd0, 1'b0);
    send(16'hFFFF, 1'b1);
    // Head at track 0 with duplicates.
    set_head(16'd0);
    send(16'd0, 1'b0);
    send(16'd7, 1'b0);
    send(16'd7, 1'b0);
    send(16'd3, 1'b1);
    // Top track as head: a lone request on the head serves only track 0.
    set_head(16'hFFFF);
    send(16'hFFFF, 1'b1);
    send(16'd0, 1'b0);
    send(16'd1, 1'b0);
    send(16'h8000, 1'b1);
    // Longest climb after the sweep end.
    set_head(16'd1);
    send(16'hFFFF, 1'b0);
    send(16'd0, 1'b1);

    prev = '0;
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       set_head('0);
          1:       set_head('1);
          default: set_head(TRACK_W'($urandom));
        endcase
      end
      quiet = (items_sent >= ITEM_GOAL - QUIET_ITEMS);
      k = $urandom_range(0, 9);
      if (k == 0) size = $urandom_range(MAX_REQ + 1, MAX_REQ + 4);
      else if (k <= 2) size = MAX_REQ;
      else size = $urandom_range(1, MAX_REQ - 1);
      if (size > MAX_REQ) overflows++;
      for (k = 0; k < size; k++) begin
        case ($urandom_range(0, 9))
          0:       trk = '0;
          1:       trk = '1;
          2:       trk = cur_head;
          3:       trk = prev;
          4, 5:    trk = cur_head + TRACK_W'($urandom_range(0, 64)) - TRACK_W'(32);
          default: trk = TRACK_W'($urandom);
        endcase
        send(trk, k == size - 1);
        prev = trk;
      end
    end

    in_valid <= 1'b0;
    drain_wait();
    $display("Covered %0d requests in %0d batches (%0d overflowing the store)",
             items_sent, batches, overflows);
    $display("under %0d start head settings; %0d tracks served and checked.",
             head_writes, tracks_served);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Watchdog expired with %0d results still pending.", outstanding);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sdhs_pkg.sv
sv/sdhs_datapath.sv
sv/sdhs_ctrl.sv
sv/scan_disk_head_scheduler.sv
sv/sdhs_checker.sv
sim/scan_order_checker.sv
sim/testbench.sv
